@@ hw/rtl/pltb_pkg.sv @@
// package: types, sizes, codes and palette helpers of the palette tile blitter
`timescale 1ns / 1ps
package pltb_pkg;

	localparam int SCREEN_SIDE  = 128;
	localparam int TILE_SIDE    = 8;
	localparam int TILE_COUNT   = 64;
	localparam int PALETTE_SIZE = 256;

	localparam int TB_MAX     = 128;
	localparam int FIRST_TILE = 2;
	localparam int TILE_PIX   = TILE_SIDE * TILE_SIDE;

	localparam int SCR_DEPTH = SCREEN_SIDE * SCREEN_SIDE;
	localparam int TB_DEPTH  = TB_MAX * TB_MAX;
	localparam int TL_DEPTH  = TILE_COUNT * TILE_PIX;

	localparam int SCR_AW = $clog2(SCR_DEPTH);
	localparam int TB_AW  = $clog2(TB_DEPTH);
	localparam int TL_AW  = $clog2(TL_DEPTH);
	localparam int PAL_AW = $clog2(PALETTE_SIZE);
	localparam int CNT_W  = ((SCR_AW > TB_AW) ? SCR_AW : TB_AW) + 1;
	localparam int TIU_W  = $clog2(TILE_COUNT + 1);
	localparam int CRD_W  = 10;

	localparam logic [15:0] PAL_RED   = 16'(31 << 11);
	localparam logic [15:0] PAL_GREEN = 16'(31 << 5);
	localparam logic [15:0] PAL_BLUE  = 16'(31);

	typedef enum logic [3:0] {
		CMD_SET_COLOR   = 4'd0,
		CMD_RESET_COLOR = 4'd1,
		CMD_BEGIN       = 4'd2,
		CMD_END         = 4'd3,
		CMD_PIXEL       = 4'd4,
		CMD_TILE        = 4'd5,
		CMD_TEXTBOX     = 4'd6,
		CMD_CLEAR       = 4'd7,
		CMD_ADD_TILE    = 4'd8,
		CMD_RESET_TILES = 4'd9,
		CMD_READ        = 4'd10
	} cmd_t;

	typedef enum logic [1:0] {
		STS_OK      = 2'd0,
		STS_IGNORED = 2'd1,
		STS_FULL    = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		CFG_MODE      = 2'd0,
		CFG_TB_WIDTH  = 2'd1,
		CFG_TB_HEIGHT = 2'd2
	} cfg_idx_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_CLEAR,
		S_COPY,
		S_DRAIN
	} state_t;

	typedef enum logic [1:0] {
		WT_SCREEN,
		WT_TEXTBOX,
		WT_TILE
	} wtgt_t;

	typedef struct packed {
		logic [3:0] cmd;
		logic [7:0] color_index;
		logic [4:0] red;
		logic [5:0] green;
		logic [4:0] blue;
		logic [6:0] pos_x;
		logic [6:0] pos_y;
		logic [6:0] buffer_id;
	} in_item_t;

	typedef struct packed {
		logic [15:0] value;
		logic [1:0]  status;
	} out_item_t;

	function automatic logic [15:0] default_color(input logic [7:0] idx);
		logic [15:0] c;
		case (idx)
			8'd0:    c = PAL_RED;
			8'd1:    c = PAL_GREEN;
			8'd2:    c = PAL_BLUE;
			default: c = 16'd0;
		endcase
		return c;
	endfunction

	function automatic logic [15:0] pack_rgb(input logic [4:0] r, input logic [5:0] g,
		input logic [4:0] b);
		return {r, g, b};
	endfunction

endpackage

@@ hw/rtl/pltb_ram.sv @@
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
module pltb_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ hw/rtl/palette_tile_blitter_top.sv @@
// top level of the palette tile blitter: command sequencer around palette and pixel rams
//
// channel | direction | handshake            | payload
// in      | input     | in_valid / in_stall   | in_data  (pltb_pkg::in_item_t)
// out     | output    | out_valid / out_stall | out_data (pltb_pkg::out_item_t)
// cfg     | input     | cfg_we                | cfg_index, cfg_data
//
// one item at a time: accept, then an execute state after the palette and screen reads
// single-step commands end in the execute state; a clear then walks its target store
// a tile copy walks the 64 tile pixels, a textbox copy width*height pixels, then a drain state
// reset puts the palette at its defaults through valid bits, no clearing pass
// a new item is taken only once the previous result has been taken
`timescale 1ns / 1ps
module palette_tile_blitter_top (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  pltb_pkg::in_item_t   in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output pltb_pkg::out_item_t  out_data,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [7:0]           cfg_data
);

	pltb_pkg::state_t    state_q, state_d;
	pltb_pkg::in_item_t  it_q;
	pltb_pkg::out_item_t out_q, res;
	pltb_pkg::wtgt_t     wtgt_q;

	logic       mode_q;
	logic [7:0] tbw_q, tbh_q, tbw_eff, tbh_eff;
	logic       tgt_vld_q;
	logic [6:0] tgt_q;
	logic [pltb_pkg::TIU_W-1:0] tiu_q;
	logic [pltb_pkg::PALETTE_SIZE-1:0] pal_vld_q;
	logic       pal_zero_q;
	logic       out_valid_q;

	logic [pltb_pkg::CNT_W-1:0] cnt_q, last_q, last_d;
	logic [7:0]  tx_q, ty_q, wlim_q;
	logic [pltb_pkg::TL_AW-1:0] base_q, base_d;
	logic [15:0] col_q, col;
	logic        copy_tile_q;
	logic        cp_vld_s1;
	logic [pltb_pkg::CRD_W-1:0] dx_s1, dy_s1;

	logic in_acc, res_vld, go_clear, go_copy, ci_ok, copy_ok, tb_empty, walk_last;
	logic [pltb_pkg::PAL_AW-1:0] pal_idx;
	logic [pltb_pkg::CNT_W-1:0]  tb_last;

	logic                         pal_we;
	logic [15:0]                  pal_rdata;
	logic                         scr_we;
	logic [pltb_pkg::SCR_AW-1:0]  scr_waddr, scr_raddr;
	logic [15:0]                  scr_wdata, scr_rdata;
	logic                         tb_we;
	logic [pltb_pkg::TB_AW-1:0]   tb_waddr, tb_raddr;
	logic [15:0]                  tb_rdata;
	logic                         tl_we;
	logic [pltb_pkg::TL_AW-1:0]   tl_waddr, tl_raddr;
	logic [15:0]                  tl_rdata;

	function automatic logic tile_ok(input logic [6:0] id, input logic [pltb_pkg::TIU_W-1:0] n);
		return (int'(id) >= pltb_pkg::FIRST_TILE) && ((int'(id) - pltb_pkg::FIRST_TILE) < int'(n));
	endfunction

	function automatic logic [pltb_pkg::TL_AW-1:0] tile_base(input logic [6:0] id);
		return pltb_pkg::TL_AW'((int'(id) - pltb_pkg::FIRST_TILE) * pltb_pkg::TILE_PIX);
	endfunction

	assign in_stall  = !((state_q == pltb_pkg::S_IDLE) && !out_valid_q);
	assign in_acc    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign tbw_eff  = (int'(tbw_q) > pltb_pkg::TB_MAX) ? 8'(pltb_pkg::TB_MAX) : tbw_q;
	assign tbh_eff  = (int'(tbh_q) > pltb_pkg::TB_MAX) ? 8'(pltb_pkg::TB_MAX) : tbh_q;
	assign tb_empty = (tbw_eff == 8'd0) || (tbh_eff == 8'd0);
	assign tb_last  = pltb_pkg::CNT_W'(int'(tbw_eff) * int'(tbh_eff) - 1);
	assign ci_ok    = int'(it_q.color_index) < pltb_pkg::PALETTE_SIZE;
	assign pal_idx  = it_q.color_index[pltb_pkg::PAL_AW-1:0];
	assign col      = pal_vld_q[pal_idx] ? pal_rdata :
		(pal_zero_q ? 16'd0 : pltb_pkg::default_color(it_q.color_index));
	assign copy_ok  = mode_q && tgt_vld_q && (tgt_q == 7'd0);
	assign walk_last = (cnt_q == last_q);

	assign go_clear = (it_q.cmd == pltb_pkg::CMD_CLEAR) && ci_ok && tgt_vld_q &&
		((tgt_q == 7'd0) || ((tgt_q == 7'd1) && !tb_empty) || tile_ok(tgt_q, tiu_q));
	assign go_copy = ((it_q.cmd == pltb_pkg::CMD_TILE) && copy_ok &&
		tile_ok(it_q.buffer_id, tiu_q)) ||
		((it_q.cmd == pltb_pkg::CMD_TEXTBOX) && copy_ok && !tb_empty);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			pltb_pkg::S_IDLE: begin
				if (in_acc) state_d = pltb_pkg::S_EXEC;
			end
			pltb_pkg::S_EXEC: begin
				if (go_clear) state_d = pltb_pkg::S_CLEAR;
				else if (go_copy) state_d = pltb_pkg::S_COPY;
				else state_d = pltb_pkg::S_IDLE;
			end
			pltb_pkg::S_CLEAR: begin
				if (walk_last) state_d = pltb_pkg::S_IDLE;
			end
			pltb_pkg::S_COPY: begin
				if (walk_last) state_d = pltb_pkg::S_DRAIN;
			end
			pltb_pkg::S_DRAIN: state_d = pltb_pkg::S_IDLE;
			default: state_d = pltb_pkg::S_IDLE;
		endcase
	end

	// walk setup values
	always_comb begin
		base_d = tile_base(it_q.buffer_id);
		last_d = pltb_pkg::CNT_W'(pltb_pkg::TILE_PIX - 1);
		if (it_q.cmd == pltb_pkg::CMD_CLEAR) begin
			base_d = tile_base(tgt_q);
			if (tgt_q == 7'd0) last_d = pltb_pkg::CNT_W'(pltb_pkg::SCR_DEPTH - 1);
			else if (tgt_q == 7'd1) last_d = tb_last;
		end else if (it_q.cmd == pltb_pkg::CMD_TEXTBOX) begin
			last_d = tb_last;
		end
	end

	// ram controls and result
	always_comb begin
		res_vld   = 1'b0;
		res.value = 16'd0;
		res.status = pltb_pkg::STS_OK;
		pal_we    = 1'b0;
		scr_we    = 1'b0;
		scr_waddr = pltb_pkg::SCR_AW'(int'(it_q.pos_y) * pltb_pkg::SCREEN_SIDE + int'(it_q.pos_x));
		scr_wdata = col;
		tb_we     = 1'b0;
		tb_waddr  = pltb_pkg::TB_AW'(int'(it_q.pos_y) * int'(tbw_eff) + int'(it_q.pos_x));
		tl_we     = 1'b0;
		tl_waddr  = tile_base(tgt_q) +
			pltb_pkg::TL_AW'(int'(it_q.pos_y) * pltb_pkg::TILE_SIDE + int'(it_q.pos_x));
		scr_raddr = pltb_pkg::SCR_AW'(int'(in_data.pos_y) * pltb_pkg::SCREEN_SIDE +
			int'(in_data.pos_x));
		tb_raddr  = pltb_pkg::TB_AW'(cnt_q);
		tl_raddr  = base_q + pltb_pkg::TL_AW'(cnt_q);
		case (state_q)
			pltb_pkg::S_EXEC: begin
				res_vld = !go_clear && !go_copy;
				case (it_q.cmd)
					pltb_pkg::CMD_SET_COLOR: begin
						if (ci_ok) pal_we = 1'b1;
						else res.status = pltb_pkg::STS_IGNORED;
					end
					pltb_pkg::CMD_RESET_COLOR, pltb_pkg::CMD_BEGIN, pltb_pkg::CMD_END,
					pltb_pkg::CMD_RESET_TILES: begin
						res.status = pltb_pkg::STS_OK;
					end
					pltb_pkg::CMD_PIXEL: begin
						res.status = pltb_pkg::STS_IGNORED;
						if (ci_ok && tgt_vld_q) begin
							if (tgt_q == 7'd0) begin
								if (int'(it_q.pos_x) < pltb_pkg::SCREEN_SIDE &&
									int'(it_q.pos_y) < pltb_pkg::SCREEN_SIDE) begin
									scr_we = 1'b1;
									res.status = pltb_pkg::STS_OK;
								end
							end else if (tgt_q == 7'd1) begin
								if ({1'b0, it_q.pos_x} < tbw_eff && {1'b0, it_q.pos_y} < tbh_eff) begin
									tb_we = 1'b1;
									res.status = pltb_pkg::STS_OK;
								end
							end else if (tile_ok(tgt_q, tiu_q) &&
								int'(it_q.pos_x) < pltb_pkg::TILE_SIDE &&
								int'(it_q.pos_y) < pltb_pkg::TILE_SIDE) begin
								tl_we = 1'b1;
								res.status = pltb_pkg::STS_OK;
							end
						end
					end
					pltb_pkg::CMD_TILE: begin
						if (!(copy_ok && tile_ok(it_q.buffer_id, tiu_q)))
							res.status = pltb_pkg::STS_IGNORED;
					end
					pltb_pkg::CMD_TEXTBOX: begin
						if (!copy_ok) res.status = pltb_pkg::STS_IGNORED;
					end
					pltb_pkg::CMD_CLEAR: begin
						if (!ci_ok || !tgt_vld_q ||
							(tgt_q != 7'd0 && tgt_q != 7'd1 && !tile_ok(tgt_q, tiu_q)))
							res.status = pltb_pkg::STS_IGNORED;
					end
					pltb_pkg::CMD_ADD_TILE: begin
						if (int'(tiu_q) >= pltb_pkg::TILE_COUNT) res.status = pltb_pkg::STS_FULL;
						else res.value = 16'(pltb_pkg::FIRST_TILE + int'(tiu_q));
					end
					pltb_pkg::CMD_READ: begin
						if (int'(it_q.pos_x) < pltb_pkg::SCREEN_SIDE &&
							int'(it_q.pos_y) < pltb_pkg::SCREEN_SIDE)
							res.value = scr_rdata;
						else res.status = pltb_pkg::STS_IGNORED;
					end
					default: res.status = pltb_pkg::STS_IGNORED;
				endcase
			end
			pltb_pkg::S_CLEAR: begin
				res_vld   = walk_last;
				scr_wdata = col_q;
				scr_waddr = pltb_pkg::SCR_AW'(cnt_q);
				tb_waddr  = pltb_pkg::TB_AW'(cnt_q);
				tl_waddr  = base_q + pltb_pkg::TL_AW'(cnt_q);
				case (wtgt_q)
					pltb_pkg::WT_SCREEN:  scr_we = 1'b1;
					pltb_pkg::WT_TEXTBOX: tb_we = 1'b1;
					pltb_pkg::WT_TILE:    tl_we = 1'b1;
					default: scr_we = 1'b0;
				endcase
			end
			pltb_pkg::S_DRAIN: res_vld = 1'b1;
			default: res_vld = 1'b0;
		endcase
		// copy write side, in the cycle after the source read
		if (cp_vld_s1) begin
			scr_wdata = copy_tile_q ? tl_rdata : tb_rdata;
			scr_waddr = pltb_pkg::SCR_AW'(int'(dy_s1) * pltb_pkg::SCREEN_SIDE + int'(dx_s1));
			scr_we = (int'(dx_s1) < pltb_pkg::SCREEN_SIDE) && (int'(dy_s1) < pltb_pkg::SCREEN_SIDE);
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pltb_pkg::S_IDLE;
			out_valid_q <= 1'b0;
			mode_q      <= 1'b0;
			tbw_q       <= 8'd100;
			tbh_q       <= 8'd64;
			tgt_vld_q   <= 1'b0;
			tgt_q       <= 7'd0;
			tiu_q       <= '0;
			pal_vld_q   <= '0;
			pal_zero_q  <= 1'b0;
			cp_vld_s1   <= 1'b0;
		end else begin
			state_q   <= state_d;
			cp_vld_s1 <= (state_q == pltb_pkg::S_COPY);
			if (res_vld) out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					pltb_pkg::CFG_MODE:      mode_q <= cfg_data[0];
					pltb_pkg::CFG_TB_WIDTH:  tbw_q <= cfg_data;
					pltb_pkg::CFG_TB_HEIGHT: tbh_q <= cfg_data;
					default: mode_q <= mode_q;
				endcase
			end
			if (state_q == pltb_pkg::S_EXEC) begin
				case (it_q.cmd)
					pltb_pkg::CMD_SET_COLOR: begin
						if (ci_ok) pal_vld_q[pal_idx] <= 1'b1;
					end
					pltb_pkg::CMD_RESET_COLOR: begin
						pal_vld_q  <= '0;
						pal_zero_q <= 1'b1;
					end
					pltb_pkg::CMD_BEGIN: begin
						tgt_vld_q <= 1'b1;
						tgt_q     <= it_q.buffer_id;
					end
					pltb_pkg::CMD_END: tgt_vld_q <= 1'b0;
					pltb_pkg::CMD_ADD_TILE: begin
						if (int'(tiu_q) < pltb_pkg::TILE_COUNT) tiu_q <= tiu_q + 1'b1;
					end
					pltb_pkg::CMD_RESET_TILES: tiu_q <= '0;
					default: tiu_q <= tiu_q;
				endcase
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc) it_q <= in_data;
		if (res_vld) out_q <= res;
		dx_s1 <= pltb_pkg::CRD_W'(it_q.pos_x) + pltb_pkg::CRD_W'(tx_q);
		dy_s1 <= pltb_pkg::CRD_W'(it_q.pos_y) + pltb_pkg::CRD_W'(ty_q);
		if (state_q == pltb_pkg::S_EXEC) begin
			cnt_q       <= '0;
			tx_q        <= 8'd0;
			ty_q        <= 8'd0;
			col_q       <= col;
			base_q      <= base_d;
			last_q      <= last_d;
			copy_tile_q <= (it_q.cmd == pltb_pkg::CMD_TILE);
			wlim_q      <= (it_q.cmd == pltb_pkg::CMD_TILE) ? 8'(pltb_pkg::TILE_SIDE) : tbw_eff;
			if (tgt_q == 7'd0) wtgt_q <= pltb_pkg::WT_SCREEN;
			else if (tgt_q == 7'd1) wtgt_q <= pltb_pkg::WT_TEXTBOX;
			else wtgt_q <= pltb_pkg::WT_TILE;
		end else begin
			cnt_q <= cnt_q + 1'b1;
			if (tx_q == wlim_q - 8'd1) begin
				tx_q <= 8'd0;
				ty_q <= ty_q + 8'd1;
			end else begin
				tx_q <= tx_q + 8'd1;
			end
		end
	end

	pltb_ram #(.WIDTH(16), .DEPTH(pltb_pkg::PALETTE_SIZE)) u_pal_ram (
		.clk   (clk),
		.we    (pal_we),
		.waddr (pal_idx),
		.wdata (pltb_pkg::pack_rgb(it_q.red, it_q.green, it_q.blue)),
		.raddr (in_data.color_index[pltb_pkg::PAL_AW-1:0]),
		.rdata (pal_rdata)
	);

	pltb_ram #(.WIDTH(16), .DEPTH(pltb_pkg::SCR_DEPTH)) u_scr_ram (
		.clk   (clk),
		.we    (scr_we),
		.waddr (scr_waddr),
		.wdata (scr_wdata),
		.raddr (scr_raddr),
		.rdata (scr_rdata)
	);

	pltb_ram #(.WIDTH(16), .DEPTH(pltb_pkg::TB_DEPTH)) u_tb_ram (
		.clk   (clk),
		.we    (tb_we),
		.waddr (tb_waddr),
		.wdata ((state_q == pltb_pkg::S_EXEC) ? col : col_q),
		.raddr (tb_raddr),
		.rdata (tb_rdata)
	);

	pltb_ram #(.WIDTH(16), .DEPTH(pltb_pkg::TL_DEPTH)) u_tl_ram (
		.clk   (clk),
		.we    (tl_we),
		.waddr (tl_waddr),
		.wdata ((state_q == pltb_pkg::S_EXEC) ? col : col_q),
		.raddr (tl_raddr),
		.rdata (tl_rdata)
	);

	a_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (state_q == pltb_pkg::S_IDLE))
		else $error("result pending outside idle");

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == pltb_pkg::S_EXEC))
		else $error("accepted item not executed");

	a_pool_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(tiu_q) <= pltb_pkg::TILE_COUNT)
		else $error("tile count above pool size");

	a_copy_write: assert property (@(posedge clk) disable iff (!arst_n)
		cp_vld_s1 |-> (state_q == pltb_pkg::S_COPY || state_q == pltb_pkg::S_DRAIN))
		else $error("copy write outside copy walk");

endmodule
